// ----- rtl/olir_pkg.sv -----
// Package for the ordered list core: field widths, operation and status codes,
// and the structs that pass between the controller, the entry memory and the top level.
// Depends on nothing.
package olir_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 6;
   localparam int ADDR_W        = 6;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;

   localparam logic [OP_W-1:0] OP_PREPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
   localparam logic [OP_W-1:0] OP_INSERT  = 2'd2;
   localparam logic [OP_W-1:0] OP_REMOVE  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic                     wr_en;
      addr_type                 wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic                     rd_en;
      addr_type                 rd_addr;
   } mem_cmd_type;

   typedef struct packed {
      logic                valid;
      logic                empty;
      logic                last;
      logic [STATUS_W-1:0] status;
   } rsp_ctl_type;

endpackage

// ----- rtl/olir_mem.sv -----
// Entry memory of the ordered list core: one write port and one read port,
// with a registered read result. Depends on olir_pkg.
module olir_mem #(
   parameter int DEPTH = olir_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  olir_pkg::mem_cmd_type               mem_cmd,
   output logic signed [olir_pkg::DATA_W-1:0]  rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [olir_pkg::DATA_W-1:0] entries_ff [DEPTH];
   logic signed [olir_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         entries_ff[mem_cmd.wr_addr[AW-1:0]] <= mem_cmd.wr_data;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= entries_ff[mem_cmd.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/olir_ctrl.sv -----
// Sequencer of the ordered list core: decodes an operation, moves entries through
// the memory one read and one write per cycle, then reads the list out in order.
// Depends on olir_pkg.
module olir_ctrl #(
   parameter int DEPTH = olir_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [olir_pkg::OP_W-1:0]           op,
   input  logic [olir_pkg::POS_W-1:0]          position,
   input  logic signed [olir_pkg::DATA_W-1:0]  item_value,
   input  logic signed [olir_pkg::DATA_W-1:0]  rd_data,
   output olir_pkg::mem_cmd_type               mem_cmd,
   output olir_pkg::rsp_ctl_type               rsp_ctl
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = (LW > olir_pkg::POS_W) ? LW : olir_pkg::POS_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type                           state_ff, state_in;
   logic [LW-1:0]                       length_ff, length_in;
   logic [LW-1:0]                       cnt_ff, cnt_in;
   logic [LW-1:0]                       src_ff, src_in;
   logic [LW-1:0]                       dest_ff, dest_in;
   logic                                wpend_ff, wpend_in;
   logic                                remove_ff, remove_in;
   logic                                ins_ff, ins_in;
   logic [AW-1:0]                       idx_ff, idx_in;
   logic signed [olir_pkg::DATA_W-1:0]  value_ff, value_in;
   logic [olir_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [LW-1:0]                       emit_ff, emit_in;
   olir_pkg::rsp_ctl_type               rsp_ff, rsp_in;

   always_comb begin
      logic [CW-1:0] len_x;
      logic [CW-1:0] pos_x;
      logic [CW-1:0] idx_x;
      logic          full;

      len_x     = CW'(length_ff);
      pos_x     = CW'(position);
      full      = (length_ff == LW'(DEPTH));
      idx_x     = '0;
      state_in  = state_ff;
      length_in = length_ff;
      cnt_in    = cnt_ff;
      src_in    = src_ff;
      dest_in   = dest_ff;
      wpend_in  = 1'b0;
      remove_in = remove_ff;
      ins_in    = ins_ff;
      idx_in    = idx_ff;
      value_in  = value_ff;
      status_in = status_ff;
      emit_in   = emit_ff;
      rsp_in    = '0;
      mem_cmd   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (op)
                  olir_pkg::OP_PREPEND: idx_x = '0;
                  olir_pkg::OP_APPEND:  idx_x = len_x;
                  olir_pkg::OP_INSERT:  idx_x = (pos_x > len_x) ? len_x : pos_x;
                  default:              idx_x = pos_x;
               endcase
               idx_in   = idx_x[AW-1:0];
               value_in = item_value;
               emit_in  = '0;
               if (op == olir_pkg::OP_REMOVE) begin
                  if (pos_x >= len_x) begin
                     status_in = olir_pkg::STATUS_RANGE;
                     state_in  = ST_EMIT;
                  end else begin
                     status_in = olir_pkg::STATUS_DONE;
                     length_in = length_ff - LW'(1);
                     cnt_in    = LW'(len_x - idx_x - CW'(1));
                     src_in    = LW'(idx_x + CW'(1));
                     remove_in = 1'b1;
                     ins_in    = 1'b0;
                     state_in  = ST_SHIFT;
                  end
               end else if (full) begin
                  status_in = olir_pkg::STATUS_FULL;
                  state_in  = ST_EMIT;
               end else begin
                  status_in = olir_pkg::STATUS_DONE;
                  length_in = length_ff + LW'(1);
                  cnt_in    = LW'(len_x - idx_x);
                  src_in    = length_ff - LW'(1);
                  remove_in = 1'b0;
                  ins_in    = 1'b1;
                  state_in  = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (wpend_ff) begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_addr = olir_pkg::addr_type'(dest_ff[AW-1:0]);
               mem_cmd.wr_data = rd_data;
            end
            if (cnt_ff != '0) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = olir_pkg::addr_type'(src_ff[AW-1:0]);
               wpend_in        = 1'b1;
               cnt_in          = cnt_ff - LW'(1);
               if (remove_ff) begin
                  dest_in = src_ff - LW'(1);
                  src_in  = src_ff + LW'(1);
               end else begin
                  dest_in = src_ff + LW'(1);
                  src_in  = src_ff - LW'(1);
               end
            end else if (!wpend_ff) begin
               if (ins_ff) begin
                  mem_cmd.wr_en   = 1'b1;
                  mem_cmd.wr_addr = olir_pkg::addr_type'(idx_ff);
                  mem_cmd.wr_data = value_ff;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_in.valid  = 1'b1;
            rsp_in.status = status_ff;
            if (length_ff == '0) begin
               rsp_in.empty = 1'b1;
               rsp_in.last  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = olir_pkg::addr_type'(emit_ff[AW-1:0]);
               emit_in         = emit_ff + LW'(1);
               if (emit_ff == length_ff - LW'(1)) begin
                  rsp_in.last = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         length_ff <= '0;
         wpend_ff  <= 1'b0;
         rsp_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         length_ff <= length_in;
         wpend_ff  <= wpend_in;
         rsp_ff    <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      src_ff    <= src_in;
      dest_ff   <= dest_in;
      remove_ff <= remove_in;
      ins_ff    <= ins_in;
      idx_ff    <= idx_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      emit_ff   <= emit_in;
   end

   assign busy    = (state_ff != ST_IDLE);
   assign rsp_ctl = rsp_ff;

endmodule

// ----- rtl/ordered_list_insert_remove_core.sv -----
// Ordered list core: an operation is accepted when start is high and busy is low.
// Steps: any entries that must move are shifted, the new item is written for an insertion,
// then the list as it stands after the operation is read out in order, one result transfer per
// entry, or one empty transfer; a dropped or out-of-range operation moves no entry. Busy stays
// high until the last result transfer is presented, so operations never overlap; the receiver cannot stall.
// Synchronous active-high reset empties the list and returns the sequencer to idle.
module ordered_list_insert_remove_core #(
   parameter int DEPTH = olir_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [olir_pkg::OP_W-1:0]           req_op,
   input  logic [olir_pkg::POS_W-1:0]          req_position,
   input  logic signed [olir_pkg::DATA_W-1:0]  req_item_value,
   output logic                                rsp_valid,
   output logic signed [olir_pkg::DATA_W-1:0]  rsp_entry_value,
   output logic                                rsp_list_empty,
   output logic                                rsp_last_entry,
   output logic [olir_pkg::STATUS_W-1:0]       rsp_op_status
);

   olir_pkg::mem_cmd_type              mem_cmd;
   olir_pkg::rsp_ctl_type              rsp_ctl;
   logic signed [olir_pkg::DATA_W-1:0] rd_data;

   olir_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .op         (req_op),
      .position   (req_position),
      .item_value (req_item_value),
      .rd_data    (rd_data),
      .mem_cmd    (mem_cmd),
      .rsp_ctl    (rsp_ctl)
   );

   olir_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_ctl.valid;
   assign rsp_list_empty  = rsp_ctl.empty;
   assign rsp_last_entry  = rsp_ctl.last;
   assign rsp_op_status   = rsp_ctl.status;
   assign rsp_entry_value = rsp_ctl.empty ? '0 : rd_data;

endmodule

// ----- rtl/olir_chk.sv -----
// Port-level checker for the ordered list core and the bind that attaches it.
// Depends on olir_pkg and ordered_list_insert_remove_core.
module olir_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic signed [olir_pkg::DATA_W-1:0]  rsp_entry_value,
   input logic                                rsp_list_empty,
   input logic                                rsp_last_entry,
   input logic [olir_pkg::STATUS_W-1:0]       rsp_op_status
);

   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_empty |-> rsp_last_entry && (rsp_entry_value == '0))
      else $error("An empty list transfer must be the last one and carry zero.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_op_status == olir_pkg::STATUS_DONE) ||
                    (rsp_op_status == olir_pkg::STATUS_FULL) ||
                    (rsp_op_status == olir_pkg::STATUS_RANGE))
      else $error("A result transfer carries an unknown status.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("The core must be busy after accepting an operation.");

   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_entry |=> rsp_valid && $stable(rsp_op_status))
      else $error("A result run must continue without gaps and keep its status.");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_last_entry)
      else $error("The core must present the last transfer when it goes idle.");

endmodule

bind ordered_list_insert_remove_core olir_chk u_olir_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_entry_value (rsp_entry_value),
   .rsp_list_empty  (rsp_list_empty),
   .rsp_last_entry  (rsp_last_entry),
   .rsp_op_status   (rsp_op_status)
);
